### sv/rbf_pkg.sv
package rbf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } rbf_state_t;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam int unsigned CFG_GAMMA  = 0;
  localparam int unsigned CFG_ACTIVE = 1;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // Pipeline depth of the per-entry datapath, from table read to accumulate.
  localparam int unsigned PIPE_DEPTH = 7;

  typedef struct packed {
    logic start;    // clear accumulator
    logic issue;    // entry read issued this cycle
    logic capture;  // query capture
  } rbf_cmd_t;

  typedef struct packed {
    logic busy;     // entries still in flight
  } rbf_stat_t;

  function automatic logic [16:0] pow2_frac(input logic [4:0] k);
    logic [16:0] v;
    begin
      case (k)
        5'd0:    v = 17'd65536;
        5'd1:    v = 17'd62757;
        5'd2:    v = 17'd60097;
        5'd3:    v = 17'd57549;
        5'd4:    v = 17'd55109;
        5'd5:    v = 17'd52773;
        5'd6:    v = 17'd50535;
        5'd7:    v = 17'd48393;
        5'd8:    v = 17'd46341;
        5'd9:    v = 17'd44453;
        5'd10:   v = 17'd42495;
        5'd11:   v = 17'd40693;
        5'd12:   v = 17'd38968;
        5'd13:   v = 17'd37316;
        5'd14:   v = 17'd35734;
        5'd15:   v = 17'd34219;
        5'd16:   v = 17'd32768;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

endpackage

### sv/rbf_stream_if.sv
interface rbf_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/rbf_ctrl.sv
module rbf_ctrl
  import rbf_pkg::*;
#(
  parameter int unsigned CW = 6,
  parameter int unsigned AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [CW-1:0] count,
  input  logic          out_taken,
  input  rbf_stat_t     stat,
  output rbf_cmd_t      cmd,
  output logic [AW-1:0] rd_addr,
  output logic          idle,
  output logic          out_pending
);

  rbf_state_t    state_r, state_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r  <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          left_nxt  = count;
          addr_nxt  = '0;
          state_nxt = (count == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        addr_nxt = addr_r + AW'(1);
        left_nxt = left_r - CW'(1);
        if (left_r == CW'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    idle        = 1'b0;
    out_pending = 1'b0;
    rd_addr     = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        idle        = 1'b1;
        cmd.start   = go;
        cmd.capture = go;
      end
      ST_RUN:   cmd.issue = 1'b1;
      ST_DRAIN: ;
      ST_OUT:   out_pending = 1'b1;
      default:  ;
    endcase
  end

endmodule

### sv/rbf_datapath.sv
module rbf_datapath
  import rbf_pkg::*;
#(
  parameter int unsigned AW       = 5,
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned FEATURES = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [15:0] in_a,
  input  logic signed [15:0] in_b,
  input  logic               in_neg,
  input  logic [23:0]        in_alpha,
  input  logic [15:0]        gamma,
  input  rbf_cmd_t           cmd,
  input  logic [AW-1:0]      rd_addr,
  output rbf_stat_t          stat,
  output logic signed [31:0] sum
);

  logic [56:0] mem [DEPTH];
  logic [56:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_a, in_b, in_neg, in_alpha};
    rd_q <= mem[rd_addr];
  end

  logic signed [15:0] qa_r, qb_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qa_r <= in_a;
      qb_r <= in_b;
    end
  end

  logic [PIPE_DEPTH-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[PIPE_DEPTH-2:0], cmd.issue};
  end
  assign stat.busy = |v_r;

  // s1: differences and squares
  logic signed [16:0] da, db;
  assign da = 17'(qa_r) - 17'(signed'(rd_q[56:41]));
  assign db = 17'(qb_r) - 17'(signed'(rd_q[40:25]));
  logic [33:0] sqa_r, sqb_r;
  logic        neg1_r;
  logic [23:0] al1_r;
  always_ff @(posedge clk) begin
    sqa_r  <= unsigned'(34'(da) * 34'(da));
    sqb_r  <= (FEATURES > 1) ? unsigned'(34'(db) * 34'(db)) : 34'd0;
    neg1_r <= rd_q[24];
    al1_r  <= rd_q[23:0];
  end

  // s2: d * gamma (35 x 16 split: d < 2^34 -> product < 2^50)
  logic [34:0] d;
  assign d = 35'(sqa_r) + 35'(sqb_r);
  logic [50:0] gd_r;
  logic        neg2_r;
  logic [23:0] al2_r;
  always_ff @(posedge clk) begin
    gd_r   <= 51'(d) * 51'(gamma);
    neg2_r <= neg1_r;
    al2_r  <= al1_r;
  end

  // s3: e and exponent base change
  logic [34:0] e;
  assign e = 35'((gd_r + 51'd32768) >> 16);
  logic        big3_r;
  logic [40:0] x_r;
  logic        neg3_r;
  logic [23:0] al3_r;
  always_ff @(posedge clk) begin
    big3_r <= (e >= 35'd16777216);
    x_r    <= 41'(e[23:0]) * 41'(LOG2E_Q16);
    neg3_r <= neg2_r;
    al3_r  <= al2_r;
  end

  // s4: table interpolation
  logic [40:0] xr;
  assign xr = (x_r + 41'd32768) >> 16;
  logic [4:0]  idx;
  logic [11:0] rr;
  logic [16:0] hi, lo;
  assign idx = {1'b0, xr[15:12]};
  assign rr  = xr[11:0];
  assign hi  = pow2_frac(idx);
  assign lo  = pow2_frac(idx + 5'd1);
  logic [28:0] dr_r;
  logic [16:0] hi4_r;
  logic [24:0] n4_r;
  logic        z4_r, neg4_r;
  logic [23:0] al4_r;
  always_ff @(posedge clk) begin
    dr_r   <= 29'(hi - lo) * 29'(rr);
    hi4_r  <= hi;
    n4_r   <= xr[40:16];
    z4_r   <= big3_r || (xr[40:16] >= 25'd17);
    neg4_r <= neg3_r;
    al4_r  <= al3_r;
  end

  // s5: shift and limit
  logic [16:0] v, vs;
  assign v  = hi4_r - 17'((dr_r + 29'd2048) >> 12);
  assign vs = v >> n4_r[4:0];
  logic [15:0] k5_r;
  logic        neg5_r;
  logic [23:0] al5_r;
  always_ff @(posedge clk) begin
    k5_r   <= z4_r ? 16'd0 : (vs[16] ? 16'hFFFF : vs[15:0]);
    neg5_r <= neg4_r;
    al5_r  <= al4_r;
  end

  // s6: alpha * K
  logic [39:0] p6_r;
  logic        neg6_r;
  always_ff @(posedge clk) begin
    p6_r   <= 40'(al5_r) * 40'(k5_r);
    neg6_r <= neg5_r;
  end

  // s7: saturating accumulate
  logic signed [33:0] w, acc;
  assign w   = 34'((p6_r + 40'd32768) >> 16);
  assign acc = 34'(sum) + (neg6_r ? -w : w);
  always_ff @(posedge clk) begin
    if (cmd.start) sum <= '0;
    else if (v_r[PIPE_DEPTH-1]) begin
      if (acc > 34'sd2147483647)       sum <= 32'sh7FFFFFFF;
      else if (acc < -34'sd2147483648) sum <= 32'sh80000000;
      else                             sum <= acc[31:0];
    end
  end

endmodule

### sv/rbf_svm_classifier.sv
// Operation: a classify issues min(active_entries,MAX_VECTORS) entry reads
// (none when no entries are active), drains the pipeline and then presents the
// result; the entry loop issues one table read per cycle into a 7-stage unit.
// Classifies do not overlap: the next is accepted the cycle after the result
// transaction; a load is written on acceptance and the block stays idle.
// Reset: synchronous active-low rst_n clears control and restores the
// registers (gamma 50.0, 28 entries); the vector table is not cleared.
module rbf_svm_classifier
  import rbf_pkg::*;
#(
  parameter int unsigned MAX_VECTORS = 32,
  parameter int unsigned FEATURES    = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  rbf_stream_if.sink  in_ch,
  rbf_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int unsigned AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int unsigned CW = $clog2(MAX_VECTORS + 1) + 1;

  // Input transaction payload: op, index, a, b, neg, alpha (63 bits)
  logic               in_op, in_neg;
  logic [4:0]         in_idx;
  logic signed [15:0] in_a, in_b;
  logic [23:0]        in_alpha;
  assign {in_op, in_idx, in_a, in_b, in_neg, in_alpha} = in_ch.data[62:0];

  logic [15:0] gamma_r;
  logic [5:0]  active_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r  <= 16'd12800;
      active_r <= 6'd28;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_GAMMA)) gamma_r  <= cfg_data;
      else                            active_r <= cfg_data[5:0];
    end
  end

  logic [CW-1:0] count;
  assign count = (32'(active_r) > MAX_VECTORS) ? CW'(MAX_VECTORS) : CW'(active_r);

  logic          idle, out_pending, go, wr_en;
  logic [AW-1:0] rd_addr;
  rbf_cmd_t      cmd;
  rbf_stat_t     stat;
  logic signed [31:0] sum;

  assign in_ch.ready = idle;
  assign go    = in_ch.valid && idle && (in_op == OP_CLASSIFY);
  // Loads beyond the table are dropped.
  assign wr_en = in_ch.valid && idle && (in_op == OP_LOAD) &&
                 (32'(in_idx) < MAX_VECTORS);

  rbf_ctrl #(.CW(CW), .AW(AW)) u_ctrl (
    .clk, .rst_n, .go, .count,
    .out_taken(out_ch.valid && out_ch.ready),
    .stat, .cmd, .rd_addr, .idle, .out_pending
  );

  rbf_datapath #(.AW(AW), .DEPTH(MAX_VECTORS), .FEATURES(FEATURES)) u_dp (
    .clk, .rst_n, .wr_en, .wr_addr(AW'(in_idx)),
    .in_a, .in_b, .in_neg, .in_alpha, .gamma(gamma_r),
    .cmd, .rd_addr, .stat, .sum
  );

  // Result transaction: {decision_value, detected}
  assign out_ch.valid = out_pending;
  assign out_ch.data  = {sum, (sum > 32'sd0)};

  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
  a_no_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !stat.busy) else $error("result before drain");

endmodule

### tb/sv/tb.sv
module tb
  import rbf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One input transaction; field order MSB first, matching the payload layout.
  typedef struct packed {
    logic               op;
    logic [4:0]         idx;
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic               neg;
    logic [23:0]        alpha;
  } sv_item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [31:0] score;
    logic               det;
  } decision_t;

  localparam int NUM_VEC = 32;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  rbf_stream_if #(.W($bits(sv_item_t)))  in_ch ();
  rbf_stream_if #(.W($bits(decision_t))) out_ch ();

  rbf_svm_classifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block state used by the decision predictor.
  logic signed [15:0] vec_a [NUM_VEC];
  logic signed [15:0] vec_b [NUM_VEC];
  logic               vec_neg [NUM_VEC];
  logic [23:0]        vec_alpha [NUM_VEC];
  logic [15:0]        gamma_q88;
  logic [5:0]         active_cnt;

  // 2^(-k/16) in Q1.16, k = 0..16.
  logic [16:0] exp2_lut [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44453, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  sv_item_t  pending_items [$];
  decision_t expected_decisions [$];

  int     errors = 0;
  longint cycle = 0;
  bit     no_idle = 0;
  bit     want_hold = 0;
  bit     hold_done = 0;
  int     tx_gap = 0;
  int     rx_stall = 0;
  int     hold_left = 0;

  // Gaussian kernel exp(-gamma*d) in Q0.16 through the 2^x fraction table.
  function automatic longint gauss_kernel(longint unsigned sq_dist);
    longint unsigned e, x, n, f, r, hi, lo, v;
    e = (longint'(gamma_q88) * sq_dist + 32768) >> 16;
    if (e >= (64'd1 << 24)) return 0;
    x = (e * longint'(LOG2E_Q16) + 32768) >> 16;
    n = x >> 16;
    if (n >= 17) return 0;
    f  = x & 64'hFFFF;
    r  = f & 64'hFFF;
    hi = exp2_lut[f >> 12];
    lo = exp2_lut[(f >> 12) + 1];
    v  = hi - (((hi - lo) * r + 2048) >> 12);
    v  = v >> n;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // Signed, saturated sum of +-alpha*K over the active entries.
  function automatic decision_t svm_decision(sv_item_t q);
    decision_t      res;
    longint         acc, da, db, w;
    longint unsigned sq_dist;
    int             count;
    acc = 0;
    count = (active_cnt > NUM_VEC) ? NUM_VEC : active_cnt;
    for (int i = 0; i < count; i++) begin
      da = longint'(q.fa) - longint'(vec_a[i]);
      db = longint'(q.fb) - longint'(vec_b[i]);
      sq_dist = da * da + db * db;
      w = (longint'(vec_alpha[i]) * gauss_kernel(sq_dist) + 32768) >> 16;
      acc = vec_neg[i] ? acc - w : acc + w;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    end
    res.score = acc[31:0];
    res.det   = (acc > 0);
    return res;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Driver: predicts at acceptance so table loads land in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the offered transaction
    end else begin
      if (in_ch.valid) begin
        sv_item_t acc_item;
        acc_item = sv_item_t'(in_ch.data);
        if (acc_item.op == OP_LOAD) begin
          vec_a[acc_item.idx]     = acc_item.fa;
          vec_b[acc_item.idx]     = acc_item.fb;
          vec_neg[acc_item.idx]   = acc_item.neg;
          vec_alpha[acc_item.idx] = acc_item.alpha;
        end else begin
          expected_decisions.push_back(svm_decision(acc_item));
        end
      end
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.data  <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
        tx_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure, one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        decision_t got, exp_d;
        got = decision_t'(out_ch.data);
        if (expected_decisions.size() == 0) begin
          $display("%0t: unexpected decision score=%0d det=%0b", $time, got.score, got.det);
          errors++;
        end else begin
          exp_d = expected_decisions.pop_front();
          if (got.score !== exp_d.score) begin
            $display("%0t: score expected %0d actual %0d", $time, exp_d.score, got.score);
            errors++;
          end
          if (got.det !== exp_d.det) begin
            $display("%0t: detected expected %0b actual %0b", $time, exp_d.det, got.det);
            errors++;
          end
        end
      end
      if (want_hold && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_stall <= pick_gap();
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == 1'(CFG_GAMMA)) gamma_q88 = val;
    else active_cnt = val[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block is idle once everything is sent and answered; loads are written on
  // acceptance, so none are left in flight. Sampled at the falling edge so the
  // driver's updates of this cycle have settled.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_ch.valid || expected_decisions.size() > 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic push_load(input int idx, input int fa, input int fb,
                           input bit neg, input int alpha);
    sv_item_t it;
    it.op = OP_LOAD; it.idx = 5'(idx); it.fa = 16'(fa); it.fb = 16'(fb);
    it.neg = neg; it.alpha = 24'(alpha);
    pending_items.push_back(it);
  endtask

  task automatic push_query(input int fa, input int fb);
    sv_item_t it;
    it = sv_item_t'(63'({$urandom, $urandom}));
    it.op = OP_CLASSIFY; it.fa = 16'(fa); it.fb = 16'(fb);
    pending_items.push_back(it);
  endtask

  // Random phase: mostly queries near stored vectors so kernels are nonzero.
  task automatic random_phase(input int n);
    int k, spread;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        push_load($urandom_range(0, 31), $urandom_range(0, 65535) - 32768,
                  $urandom_range(0, 65535) - 32768, $urandom_range(0, 1),
                  $urandom_range(0, 24'hFFFFFF));
      end else if ($urandom_range(0, 9) < 6) begin
        k = $urandom_range(0, 31);
        spread = 1 << $urandom_range(0, 12);
        push_query(int'(vec_a[k]) + $urandom_range(0, 2 * spread) - spread,
                   int'(vec_b[k]) + $urandom_range(0, 2 * spread) - spread);
      end else begin
        push_query($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    gamma_q88 = 16'd12800;
    active_cnt = 6'd28;
    for (int i = 0; i < NUM_VEC; i++) begin
      vec_a[i] = '0; vec_b[i] = '0; vec_neg[i] = 1'b0; vec_alpha[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every entry before any query reads the table; extremes first.
    push_load(0, -32768, -32768, 1'b0, 24'hFFFFFF);
    push_load(1, 32767, 32767, 1'b1, 24'hFFFFFF);
    push_load(2, 0, 0, 1'b0, 0);
    push_load(31, -32768, 32767, 1'b1, 1);
    for (int i = 3; i < 31; i++)
      push_load(i, $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                $urandom_range(0, 1), $urandom_range(0, 24'hFFFFFF));
    // Directed queries at reset settings: exact hit (kernel of one), far away
    // (large exponent), field extremes.
    push_query(-32768, -32768);
    push_query(32767, 32767);
    push_query(0, 0);
    push_query(-32768, 32767);
    push_query(32767, -32768);
    push_query(1, -1);
    wait_idle();

    // gamma zero: every kernel saturates at one; all entries summed
    write_reg(1'(CFG_GAMMA), 16'd0);
    write_reg(1'(CFG_ACTIVE), 16'd32);
    push_query(0, 0);
    push_query(32767, -32768);
    wait_idle();

    // single entry, steepest kernel
    write_reg(1'(CFG_GAMMA), 16'hFFFF);
    write_reg(1'(CFG_ACTIVE), 16'd1);
    push_query(-32768, -32768);
    push_query(-32767, -32768);
    random_phase(150);
    wait_idle();

    // count beyond the table, tiny gamma; no idling for this stretch
    no_idle = 1;
    write_reg(1'(CFG_GAMMA), 16'd1);
    write_reg(1'(CFG_ACTIVE), 16'd63);
    random_phase(150);
    wait_idle();
    no_idle = 0;

    // zero active entries gives a sum of zero
    write_reg(1'(CFG_ACTIVE), 16'd0);
    push_query(123, -456);
    random_phase(20);
    wait_idle();

    // reset default settings; receiver holds off so the block backs up
    write_reg(1'(CFG_GAMMA), 16'd12800);
    write_reg(1'(CFG_ACTIVE), 16'd28);
    want_hold = 1;
    random_phase(200);
    wait_idle();

    write_reg(1'(CFG_GAMMA), 16'($urandom_range(16, 2048)));
    write_reg(1'(CFG_ACTIVE), 16'($urandom_range(1, 32)));
    random_phase(200);
    wait_idle();

    write_reg(1'(CFG_GAMMA), 16'($urandom_range(0, 65535)));
    write_reg(1'(CFG_ACTIVE), 16'($urandom_range(1, 32)));
    random_phase(180);
    wait_idle();

    if (errors == 0 && expected_decisions.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
